@@ rtl/jtmcc_pkg.sv @@
// Shared constants, types and helpers for the joystick to MIDI CC converter.
package jtmcc_pkg;

  localparam int NUM_STICKS    = 2;
  localparam int POSITION_BITS = 16;
  localparam int CONTROLS      = 7;
  localparam int AXES          = 3;
  localparam int MAP_BITS      = 56;
  localparam int AXIS_REG_BITS = 48;
  localparam int DATA_BITS     = 64;
  localparam int ADDR_BITS     = 6;
  localparam int CTRL_BITS     = 3;
  localparam int Q_BITS        = 8;
  localparam int SLOTS         = CONTROLS * NUM_STICKS;
  localparam int SLOT_BITS     = $clog2(SLOTS);

  // register indexes (byte address / 8)
  localparam logic [2:0] REG_CHANNEL  = 3'd0;
  localparam logic [2:0] REG_MAP_1    = 3'd1;
  localparam logic [2:0] REG_MAP_2    = 3'd2;
  localparam logic [2:0] REG_AMIN_1   = 3'd3;
  localparam logic [2:0] REG_AMAX_1   = 3'd4;
  localparam logic [2:0] REG_AMIN_2   = 3'd5;
  localparam logic [2:0] REG_AMAX_2   = 3'd6;

  localparam logic [7:0] CC_STATUS    = 8'hB0;
  localparam logic [6:0] TOP_VALUE    = 7'd127;
  localparam logic [7:0] NOTHING_SENT = 8'hFF;

  typedef logic [POSITION_BITS-1:0] pos_t;

  typedef struct packed {
    logic [3:0]                          channel;
    logic [1:0][MAP_BITS-1:0]            cc_map;
    logic [1:0][AXIS_REG_BITS-1:0]       axis_min;
    logic [1:0][AXIS_REG_BITS-1:0]       axis_max;
  } cfg_t;

  typedef struct packed {
    logic start;
    pos_t dividend;
    pos_t divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [Q_BITS-1:0] quotient;
  } div_rsp_t;

  // slice k of a packed axis register; slices past the top read as zero
  function automatic pos_t axis_slice(input logic [AXIS_REG_BITS-1:0] r,
                                      input logic [CTRL_BITS-1:0] k);
    logic [AXIS_REG_BITS-1:0] sh;
    sh = r >> (POSITION_BITS * int'(k));
    return sh[POSITION_BITS-1:0];
  endfunction

  function automatic logic [7:0] cc_byte(input logic [MAP_BITS-1:0] m,
                                         input logic [CTRL_BITS-1:0] k);
    logic [MAP_BITS-1:0] sh;
    sh = m >> (8 * int'(k));
    return sh[7:0];
  endfunction

endpackage

@@ rtl/jtmcc_regs.sv @@
// APB-style configuration register file.
module jtmcc_regs import jtmcc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[ADDR_BITS-1:3];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel  <= '0;
      cfg_r.cc_map   <= '1;
      cfg_r.axis_min <= '0;
      cfg_r.axis_max <= '1;
    end else if (wr_en) begin
      case (idx)
        REG_CHANNEL: cfg_r.channel     <= pwdata[3:0];
        REG_MAP_1:   cfg_r.cc_map[0]   <= pwdata[MAP_BITS-1:0];
        REG_MAP_2:   cfg_r.cc_map[1]   <= pwdata[MAP_BITS-1:0];
        REG_AMIN_1:  cfg_r.axis_min[0] <= pwdata[AXIS_REG_BITS-1:0];
        REG_AMAX_1:  cfg_r.axis_max[0] <= pwdata[AXIS_REG_BITS-1:0];
        REG_AMIN_2:  cfg_r.axis_min[1] <= pwdata[AXIS_REG_BITS-1:0];
        REG_AMAX_2:  cfg_r.axis_max[1] <= pwdata[AXIS_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CHANNEL: prdata = DATA_BITS'(cfg_r.channel);
      REG_MAP_1:   prdata = DATA_BITS'(cfg_r.cc_map[0]);
      REG_MAP_2:   prdata = DATA_BITS'(cfg_r.cc_map[1]);
      REG_AMIN_1:  prdata = DATA_BITS'(cfg_r.axis_min[0]);
      REG_AMAX_1:  prdata = DATA_BITS'(cfg_r.axis_max[0]);
      REG_AMIN_2:  prdata = DATA_BITS'(cfg_r.axis_min[1]);
      REG_AMAX_2:  prdata = DATA_BITS'(cfg_r.axis_max[1]);
      default:     prdata = '0;
    endcase
  end

endmodule

@@ rtl/jtmcc_div.sv @@
// Shared restoring divider: floor(dividend * 128 / divisor), one quotient bit a cycle.
module jtmcc_div import jtmcc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic                   first_r, first_nxt;
  logic [2:0]             cnt_r, cnt_nxt;
  logic [POSITION_BITS:0] rem_r, rem_nxt;
  pos_t                   dvs_r, dvs_nxt;
  logic [Q_BITS-1:0]      q_r, q_nxt;
  logic [POSITION_BITS:0] trial;
  logic                   ge;

  // dividend <= divisor, so the first step needs no shift; the remainder
  // stays below the divisor afterwards and a left shift fits one extra bit
  assign trial = first_r ? rem_r : {rem_r[POSITION_BITS-1:0], 1'b0};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    first_nxt = first_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    q_nxt     = q_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      first_nxt = 1'b1;
      cnt_nxt   = '0;
      rem_nxt   = {1'b0, req.dividend};
      dvs_nxt   = req.divisor;
    end else if (busy_r) begin
      first_nxt = 1'b0;
      rem_nxt   = ge ? trial - {1'b0, dvs_r} : trial;
      q_nxt     = {q_r[Q_BITS-2:0], ge};
      cnt_nxt   = cnt_r + 3'd1;
      if (cnt_r == 3'(Q_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    first_r <= first_nxt;
    cnt_r   <= cnt_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    q_r     <= q_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

@@ rtl/joystick_to_midi_cc_top.sv @@
// Joystick poll to MIDI control-change converter, top level.
// One poll (stick, three axes, four buttons) is taken when in_ready is high, which is only
// while the block is idle. The seven controls are then walked in order x, y, z, a, b, c, d:
// an unassigned control takes only the calc step, a button or an empty-range axis the calc
// and compare steps, and any other axis also a divide step between them, in the shared
// one-bit-a-cycle divider that scales the clamped position to 0..127. A scan of the seven
// controls then hands out the changed ones one word per cycle through an output register,
// stalling while a word waits and out_ready is held low.
// last_in_run marks the final word of a poll; a poll with no changes gives no word.
// Config registers sit at 8-byte steps and must be written while the block is idle.
module joystick_to_midi_cc_top import jtmcc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_stick_select,
  input  pos_t                 in_x_position,
  input  pos_t                 in_y_position,
  input  pos_t                 in_z_position,
  input  logic [3:0]           in_button_bits,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_status_byte,
  output logic [6:0]           out_controller,
  output logic [6:0]           out_cc_value,
  output logic                 out_last_in_run,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CALC = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_SCAN = 3'd4;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  jtmcc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  jtmcc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  logic [2:0]           state_r, state_nxt;
  logic [CTRL_BITS-1:0] k_r, k_nxt;
  logic                 stick_r, stick_nxt;
  pos_t                 pos_r [AXES];
  pos_t                 pos_nxt [AXES];
  logic [3:0]           btn_r, btn_nxt;
  logic [6:0]           cur_r, cur_nxt;
  logic [CONTROLS-1:0]  emit_r, emit_nxt;
  logic [6:0]           vals_r [CONTROLS];
  logic [7:0]           last_r [SLOTS];
  logic                 out_valid_r, out_valid_nxt;
  logic [6:0]           out_ctl_r, out_ctl_nxt;
  logic [6:0]           out_val_r, out_val_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 vals_we;
  logic                 last_we;
  logic [SLOT_BITS-1:0] slot;
  logic [7:0]           ccb;
  logic [1:0]           ax;
  logic [1:0]           bidx;
  pos_t                 lo, hi, p, pc;
  logic                 empty;
  logic                 k_end;
  logic                 stick_ok;
  logic                 higher_pending;

  assign in_ready = (state_r == ST_IDLE);
  assign stick_ok = (int'(in_stick_select) < NUM_STICKS);
  assign k_end    = (k_r == CTRL_BITS'(CONTROLS - 1));
  assign slot     = SLOT_BITS'(stick_r ? CONTROLS : 0) + SLOT_BITS'(k_r);
  assign ccb      = cc_byte(cfg.cc_map[stick_r], k_r);
  assign ax       = (k_r < CTRL_BITS'(AXES)) ? k_r[1:0] : 2'd0;
  assign bidx     = 2'(k_r - CTRL_BITS'(AXES));
  assign lo       = axis_slice(cfg.axis_min[stick_r], k_r);
  assign hi       = axis_slice(cfg.axis_max[stick_r], k_r);
  assign p        = pos_r[ax];
  assign empty    = hi <= lo;
  assign pc       = (p < lo) ? lo : ((p > hi) ? hi : p);

  // any later control still to send in this poll
  always_comb begin
    higher_pending = 1'b0;
    for (int j = 0; j < CONTROLS; j++) begin
      if (j > int'(k_r) && emit_r[j]) higher_pending = 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    stick_nxt     = stick_r;
    pos_nxt       = pos_r;
    btn_nxt       = btn_r;
    cur_nxt       = cur_r;
    emit_nxt      = emit_r;
    vals_we       = 1'b0;
    last_we       = 1'b0;
    out_valid_nxt = out_valid_r;
    out_ctl_nxt   = out_ctl_r;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;
    div_req.start    = 1'b0;
    div_req.dividend = pc - lo;
    div_req.divisor  = hi - lo;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          stick_nxt  = in_stick_select;
          pos_nxt[0] = pos_t'(in_x_position);
          pos_nxt[1] = pos_t'(in_y_position);
          pos_nxt[2] = pos_t'(in_z_position);
          btn_nxt    = in_button_bits;
          k_nxt      = '0;
          emit_nxt   = '0;
          if (stick_ok) state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (ccb[7]) begin
          if (k_end) begin
            state_nxt = ST_SCAN;
            k_nxt     = '0;
          end else begin
            k_nxt = k_r + CTRL_BITS'(1);
          end
        end else if (k_r < CTRL_BITS'(AXES)) begin
          if (empty) begin
            cur_nxt   = '0;
            state_nxt = ST_CMP;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = ST_DIV;
          end
        end else begin
          cur_nxt   = btn_r[bidx] ? TOP_VALUE : 7'd0;
          state_nxt = ST_CMP;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          // full travel gives 128; clip to 127
          cur_nxt   = div_rsp.quotient[Q_BITS-1] ? TOP_VALUE : div_rsp.quotient[6:0];
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if ({1'b0, cur_r} != last_r[slot]) begin
          emit_nxt[k_r] = 1'b1;
          vals_we       = 1'b1;
          last_we       = 1'b1;
        end
        if (k_end) begin
          state_nxt = ST_SCAN;
          k_nxt     = '0;
        end else begin
          k_nxt     = k_r + CTRL_BITS'(1);
          state_nxt = ST_CALC;
        end
      end
      ST_SCAN: begin
        if (!emit_r[k_r] || !out_valid_r || out_ready) begin
          if (emit_r[k_r]) begin
            out_valid_nxt = 1'b1;
            out_ctl_nxt   = ccb[6:0];
            out_val_nxt   = vals_r[k_r];
            out_last_nxt  = !higher_pending;
          end
          if (k_end) state_nxt = ST_IDLE;
          else       k_nxt     = k_r + CTRL_BITS'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) last_r[i] <= NOTHING_SENT;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (last_we) last_r[slot] <= {1'b0, cur_r};
    end
    k_r        <= k_nxt;
    stick_r    <= stick_nxt;
    pos_r      <= pos_nxt;
    btn_r      <= btn_nxt;
    cur_r      <= cur_nxt;
    emit_r     <= emit_nxt;
    out_ctl_r  <= out_ctl_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
    if (vals_we) vals_r[k_r] <= cur_r;
  end

  assign out_valid       = out_valid_r;
  assign out_status_byte = CC_STATUS | {4'd0, cfg.channel};
  assign out_controller  = out_ctl_r;
  assign out_cc_value    = out_val_r;
  assign out_last_in_run = out_last_r;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide step");

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> div_rsp.quotient <= 8'd128)
    else $error("scaled axis quotient above 128");

  a_load_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == ST_SCAN)
    else $error("output word loaded outside the scan");

endmodule
